>>> src/cvf_pkg.sv
// Shared types, constants and helper functions for the 3x3 convolution filter.
package cvf_pkg;

    localparam int GEO_W     = 14;   // width/height register width
    localparam int ROW_W     = 13;   // row counter, up to 8192 rows
    localparam int MAX_ROWS  = 8192;
    localparam int TAPS      = 9;
    localparam int TAP_W     = 4;
    localparam int STEP_W    = 5;
    localparam int SUM_W     = 19;   // signed channel sum
    localparam int MAG_W     = 18;   // magnitude of a non-negative sum
    localparam int DIV_W     = 10;
    localparam int DIV_STEPS = 18;
    localparam int WGT_W     = 7;
    localparam int KER_W     = 63;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [2:0] REG_KERNEL  = 3'd0;
    localparam logic [2:0] REG_DIVISOR = 3'd1;
    localparam logic [2:0] REG_WIDTH   = 3'd2;
    localparam logic [2:0] REG_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_FORMAT  = 3'd4;

    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_RGBA = 2'd2;

    localparam logic [7:0] CH_MAX = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TAIL,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } state_t;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [KER_W-1:0] weights;
        logic [DIV_W-1:0] divisor;
        logic [GEO_W-1:0] width;
        logic [GEO_W-1:0] height;
        logic             gray;
        logic             rgba;
    } cfg_t;

    typedef struct packed {
        logic              accept_pix;
        logic              start_win;
        logic              start_brd;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              div_start;
        logic              div_step;
        logic              load_out;
        logic              finish;
    } cmd_t;

    typedef struct packed {
        logic emit_pix;
        logic can_flush;
        logic interior;
    } sts_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                 input logic nb,
                                                 input logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic [DIV_W:0] s;
        t = {rem, nb};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            div_step = {1'b1, s[DIV_W-1:0]};
        end else begin
            div_step = {1'b0, t[DIV_W-1:0]};
        end
    endfunction

    function automatic logic [7:0] clamp_q(input logic neg, input logic [MAG_W-1:0] q);
        if (neg) begin
            clamp_q = 8'd0;
        end else if (|q[MAG_W-1:8]) begin
            clamp_q = CH_MAX;
        end else begin
            clamp_q = q[7:0];
        end
    endfunction

endpackage

>>> src/cvf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16387
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/cvf_ctrl.sv
// Sequencer: accepts words, runs window reads, the divider and the output load.
module cvf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_operation,
    output logic                s_ready,
    input  logic                m_ready,
    output logic                m_valid,
    input  cvf_pkg::sts_t       sts,
    output cvf_pkg::cmd_t       cmd
);
    cvf_pkg::state_t            state_reg, state_next;
    logic [cvf_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       win_reg, win_next;
    logic                       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cvf_pkg::ST_IDLE;
            step_reg    <= '0;
            win_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            win_reg     <= win_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        logic go;
        go           = 1'b0;
        state_next   = state_reg;
        step_next    = step_reg;
        win_next     = win_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.step     = step_reg;
        s_ready      = 1'b0;

        case (state_reg)
            cvf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == cvf_pkg::OP_PIXEL) begin
                        cmd.accept_pix = 1'b1;
                        go = sts.emit_pix;
                    end else begin
                        go = sts.can_flush && !sts.interior;
                    end
                end
                if (go) begin
                    win_next  = sts.interior;
                    step_next = '0;
                    state_next = cvf_pkg::ST_READ;
                    if (sts.interior) begin
                        cmd.start_win = 1'b1;
                    end else begin
                        cmd.start_brd = 1'b1;
                    end
                end
            end
            cvf_pkg::ST_READ: begin
                cmd.issue = 1'b1;
                step_next = step_reg + 1'b1;
                if (!win_reg || step_reg == cvf_pkg::STEP_W'(cvf_pkg::TAPS - 1)) begin
                    state_next = cvf_pkg::ST_TAIL;
                end
            end
            cvf_pkg::ST_TAIL: begin
                state_next = win_reg ? cvf_pkg::ST_DINIT : cvf_pkg::ST_OUT;
            end
            cvf_pkg::ST_DINIT: begin
                cmd.div_start = 1'b1;
                step_next  = '0;
                state_next = cvf_pkg::ST_DIV;
            end
            cvf_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == cvf_pkg::STEP_W'(cvf_pkg::DIV_STEPS - 1)) begin
                    state_next = cvf_pkg::ST_OUT;
                end
            end
            cvf_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = cvf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cvf_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
endmodule

>>> src/cvf_dp.sv
// Datapath: line store addressing, window MAC, dividers, output word.
module cvf_dp #(
    parameter int MAX_LINE = 8192
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cvf_pkg::cfg_t cfg,
    input  logic          geo_clear,
    input  cvf_pkg::cmd_t cmd,
    output cvf_pkg::sts_t sts,
    input  logic [7:0]    s_in_red,
    input  logic [7:0]    s_in_green,
    input  logic [7:0]    s_in_blue,
    input  logic [7:0]    s_in_alpha,
    output logic [7:0]    m_out_red,
    output logic [7:0]    m_out_green,
    output logic [7:0]    m_out_blue,
    output logic [7:0]    m_out_alpha,
    output logic          m_was_filtered,
    output logic          m_frame_end
);
    localparam int DEPTH = 2 * MAX_LINE + 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_LINE + 3);
    localparam int CW    = $clog2(MAX_LINE);
    localparam int XW    = cvf_pkg::GEO_W + 2;   // compare width
    localparam int SW    = cvf_pkg::SUM_W;
    localparam int MW    = cvf_pkg::MAG_W;
    localparam int DW    = cvf_pkg::DIV_W;

    logic [AW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  pend_reg;
    logic [CW-1:0]  col_reg;
    logic [cvf_pkg::ROW_W-1:0] row_reg;
    logic [AW-1:0]  addr_reg;
    logic           rd_vld_reg;
    logic [cvf_pkg::TAP_W-1:0] tap_reg;
    logic           win_reg;
    logic [31:0]    pix_reg;
    logic signed [SW-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic [MW-1:0]  num_r_reg, num_g_reg, num_b_reg;
    logic [DW-1:0]  rem_r_reg, rem_g_reg, rem_b_reg;
    logic           neg_r_reg, neg_g_reg, neg_b_reg;

    logic [31:0]    rdata;
    logic [AW-1:0]  waddr;
    logic [AW:0]    wsum, bsum, nsum;
    logic [AW-1:0]  base_addr, next_addr;
    logic [XW-1:0]  w_x, h_x, col_x, row_x, pend_x;
    logic           row_jump;
    logic signed [cvf_pkg::WGT_W-1:0] wt;
    logic signed [SW-1:0] prod_r, prod_g, prod_b;
    logic [DW:0]    ds_r, ds_g, ds_b;
    logic [7:0]     q_r, q_g, q_b;

    cvf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (cmd.accept_pix),
        .waddr (waddr),
        .wdata ({s_in_alpha, s_in_blue, s_in_green, s_in_red}),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign w_x    = XW'(cfg.width);
    assign h_x    = XW'(cfg.height);
    assign col_x  = XW'(col_reg);
    assign row_x  = XW'(row_reg);
    assign pend_x = XW'(pend_reg);

    // circular store addressing, each sum below twice the depth
    assign wsum      = {1'b0, rd_ptr_reg} + (AW+1)'(pend_reg);
    assign waddr     = (wsum >= (AW+1)'(DEPTH)) ? AW'(wsum - (AW+1)'(DEPTH)) : wsum[AW-1:0];
    assign bsum      = {1'b0, rd_ptr_reg} + (AW+1)'(DEPTH) - (AW+1)'(cfg.width) - 1'b1;
    assign base_addr = (bsum >= (AW+1)'(DEPTH)) ? AW'(bsum - (AW+1)'(DEPTH)) : bsum[AW-1:0];
    assign row_jump  = (cmd.step == cvf_pkg::STEP_W'(2)) || (cmd.step == cvf_pkg::STEP_W'(5));
    assign nsum      = {1'b0, addr_reg} +
                       (row_jump ? ((AW+1)'(cfg.width) - (AW+1)'(2)) : (AW+1)'(1));
    assign next_addr = (nsum >= (AW+1)'(DEPTH)) ? AW'(nsum - (AW+1)'(DEPTH)) : nsum[AW-1:0];

    // status for the sequencer
    always_comb begin
        sts.emit_pix  = pend_x >= w_x + XW'(1);
        sts.can_flush = pend_reg != '0;
        sts.interior  = (cfg.divisor != '0) && (w_x >= XW'(3)) && (h_x >= XW'(3)) &&
                        (row_x >= XW'(1)) && (row_x + XW'(2) <= h_x) &&
                        (col_x >= XW'(1)) && (col_x + XW'(2) <= w_x);
    end

    assign wt     = $signed(cfg.weights[cvf_pkg::WGT_W*tap_reg +: cvf_pkg::WGT_W]);
    assign prod_r = SW'(wt) * $signed(SW'({1'b0, rdata[7:0]}));
    assign prod_g = SW'(wt) * $signed(SW'({1'b0, rdata[15:8]}));
    assign prod_b = SW'(wt) * $signed(SW'({1'b0, rdata[23:16]}));

    assign ds_r = cvf_pkg::div_step(rem_r_reg, num_r_reg[MW-1], cfg.divisor);
    assign ds_g = cvf_pkg::div_step(rem_g_reg, num_g_reg[MW-1], cfg.divisor);
    assign ds_b = cvf_pkg::div_step(rem_b_reg, num_b_reg[MW-1], cfg.divisor);

    // after the last step the numerator registers hold the quotients
    assign q_r = cvf_pkg::clamp_q(neg_r_reg, num_r_reg);
    assign q_g = cvf_pkg::clamp_q(neg_g_reg, num_g_reg);
    assign q_b = cvf_pkg::clamp_q(neg_b_reg, num_b_reg);

    // stream position and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            pend_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            rd_vld_reg <= 1'b0;
            win_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.issue;
            if (cmd.start_win) begin
                win_reg <= 1'b1;
            end else if (cmd.start_brd) begin
                win_reg <= 1'b0;
            end
            if (geo_clear) begin
                pend_reg <= '0;
                col_reg  <= '0;
                row_reg  <= '0;
            end else if (cmd.accept_pix) begin
                pend_reg <= pend_reg + 1'b1;
            end else if (cmd.finish) begin
                pend_reg   <= pend_reg - 1'b1;
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                if (col_x + XW'(1) >= w_x) begin
                    col_reg <= '0;
                    if (row_x + XW'(1) >= h_x) begin
                        row_reg <= '0;
                    end else begin
                        row_reg <= row_reg + 1'b1;
                    end
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // window reads, accumulation and division
    always_ff @(posedge aclk) begin
        if (cmd.start_win) begin
            addr_reg  <= base_addr;
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end else if (cmd.start_brd) begin
            addr_reg <= rd_ptr_reg;
        end else if (cmd.issue) begin
            addr_reg <= next_addr;
        end
        if (cmd.issue) begin
            tap_reg <= cmd.step[cvf_pkg::TAP_W-1:0];
        end
        if (rd_vld_reg) begin
            pix_reg <= rdata;
            if (win_reg) begin
                acc_r_reg <= acc_r_reg + prod_r;
                acc_g_reg <= acc_g_reg + prod_g;
                acc_b_reg <= acc_b_reg + prod_b;
            end
        end
        if (cmd.div_start) begin
            num_r_reg <= acc_r_reg[MW-1:0];
            num_g_reg <= acc_g_reg[MW-1:0];
            num_b_reg <= acc_b_reg[MW-1:0];
            neg_r_reg <= acc_r_reg[SW-1];
            neg_g_reg <= acc_g_reg[SW-1];
            neg_b_reg <= acc_b_reg[SW-1];
            rem_r_reg <= '0;
            rem_g_reg <= '0;
            rem_b_reg <= '0;
        end else if (cmd.div_step) begin
            num_r_reg <= {num_r_reg[MW-2:0], ds_r[DW]};
            num_g_reg <= {num_g_reg[MW-2:0], ds_g[DW]};
            num_b_reg <= {num_b_reg[MW-2:0], ds_b[DW]};
            rem_r_reg <= ds_r[DW-1:0];
            rem_g_reg <= ds_g[DW-1:0];
            rem_b_reg <= ds_b[DW-1:0];
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_frame_end    <= (row_x + XW'(1) >= h_x) && (col_x + XW'(1) >= w_x);
            m_was_filtered <= win_reg;
            if (win_reg) begin
                m_out_red   <= q_r;
                m_out_green <= cfg.gray ? q_r : q_g;
                m_out_blue  <= cfg.gray ? q_r : q_b;
                m_out_alpha <= cvf_pkg::CH_MAX;
            end else begin
                m_out_red   <= pix_reg[7:0];
                m_out_green <= cfg.gray ? pix_reg[7:0] : pix_reg[15:8];
                m_out_blue  <= cfg.gray ? pix_reg[7:0] : pix_reg[23:16];
                m_out_alpha <= cfg.rgba ? pix_reg[31:24] : cvf_pkg::CH_MAX;
            end
        end
    end
endmodule

>>> src/convolution_3x3_rgb_filter.sv
// Top level: register port, effective geometry, sequencer and datapath.
// A border word is the pixel read back from the line store; a filtered word needs
// 9 line store reads, then an 18-step divider, before the output load.
// The input is not ready again until the word it released is loaded for output; the
// pace is set by the single read port of the line store and the bit-per-cycle dividers.
// Reset (aresetn, synchronous, low) restores the configuration registers and clears
// the control state; the line store is not cleared and holds nothing valid after reset.
module convolution_3x3_rgb_filter #(
    parameter int MAX_LINE = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    input  logic [7:0]  s_in_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic [7:0]  m_out_alpha,
    output logic        m_was_filtered,
    output logic        m_frame_end
);
    localparam int GW = cvf_pkg::GEO_W;

    logic [cvf_pkg::KER_W-1:0] kernel_reg;
    logic [cvf_pkg::DIV_W-1:0] divisor_reg;
    logic [GW-1:0]             width_reg;
    logic [GW-1:0]             height_reg;
    logic [1:0]                format_reg;
    logic                      wr_en;
    logic [2:0]                reg_idx;
    logic                      geo_clear;
    cvf_pkg::cfg_t             cfg;
    cvf_pkg::cmd_t             cmd;
    cvf_pkg::sts_t             sts;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_idx   = paddr[5:3];
    assign geo_clear = wr_en && (reg_idx == cvf_pkg::REG_WIDTH ||
                                 reg_idx == cvf_pkg::REG_HEIGHT ||
                                 reg_idx == cvf_pkg::REG_FORMAT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg  <= cvf_pkg::KER_W'(268435456);
            divisor_reg <= cvf_pkg::DIV_W'(1);
            width_reg   <= GW'(640);
            height_reg  <= GW'(480);
            format_reg  <= cvf_pkg::FMT_RGBA;
        end else if (wr_en) begin
            case (reg_idx)
                cvf_pkg::REG_KERNEL:  kernel_reg  <= pwdata[cvf_pkg::KER_W-1:0];
                cvf_pkg::REG_DIVISOR: divisor_reg <= pwdata[cvf_pkg::DIV_W-1:0];
                cvf_pkg::REG_WIDTH:   width_reg   <= pwdata[GW-1:0];
                cvf_pkg::REG_HEIGHT:  height_reg  <= pwdata[GW-1:0];
                cvf_pkg::REG_FORMAT:  format_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cvf_pkg::REG_KERNEL:  prdata = 64'(kernel_reg);
            cvf_pkg::REG_DIVISOR: prdata = 64'(divisor_reg);
            cvf_pkg::REG_WIDTH:   prdata = 64'(width_reg);
            cvf_pkg::REG_HEIGHT:  prdata = 64'(height_reg);
            cvf_pkg::REG_FORMAT:  prdata = 64'(format_reg);
            default:              prdata = '0;
        endcase
    end

    // zero reads as one, oversize clips to the line store / row limit
    always_comb begin
        cfg.weights = kernel_reg;
        cfg.divisor = divisor_reg;
        if (width_reg == '0) begin
            cfg.width = GW'(1);
        end else if (width_reg > GW'(MAX_LINE)) begin
            cfg.width = GW'(MAX_LINE);
        end else begin
            cfg.width = width_reg;
        end
        if (height_reg == '0) begin
            cfg.height = GW'(1);
        end else if (height_reg > GW'(cvf_pkg::MAX_ROWS)) begin
            cfg.height = GW'(cvf_pkg::MAX_ROWS);
        end else begin
            cfg.height = height_reg;
        end
        cfg.gray = format_reg == cvf_pkg::FMT_GRAY;
        cfg.rgba = format_reg != cvf_pkg::FMT_GRAY && format_reg != cvf_pkg::FMT_RGB;
    end

    cvf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .sts         (sts),
        .cmd         (cmd)
    );

    cvf_dp #(.MAX_LINE(MAX_LINE)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .geo_clear      (geo_clear),
        .cmd            (cmd),
        .sts            (sts),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .s_in_alpha     (s_in_alpha),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_out_alpha    (m_out_alpha),
        .m_was_filtered (m_was_filtered),
        .m_frame_end    (m_frame_end)
    );

    // a flush with nothing pending releases no word
    a_empty_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == cvf_pkg::OP_FLUSH && !sts.can_flush
        |=> s_ready)
        else $error("empty flush started a result");

    // a pixel that releases nothing leaves the block ready
    a_quiet_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == cvf_pkg::OP_PIXEL && !sts.emit_pix
        |=> s_ready)
        else $error("pixel without release stalled the input");

    // filtered words always carry opaque alpha
    a_filt_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_filtered |-> m_out_alpha == cvf_pkg::CH_MAX)
        else $error("filtered word with non-opaque alpha");

    // the output word is loaded only after a start of work
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !s_ready)
        else $error("output load while idle");
endmodule

>>> dv/testbench.sv
// Self-checking testbench for the 3x3 convolution filter: APB setup, stream driver, checker.
`timescale 1ns / 1ps

module testbench;

    localparam int LINE_MAX    = 8192;
    localparam int STORE_WORDS = 2 * LINE_MAX + 3;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic       op;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       filt;
        logic       fend;
    } pix_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0, s_ready;
    logic        s_operation = cvf_pkg::OP_PIXEL;
    logic [7:0]  s_in_red = '0, s_in_green = '0, s_in_blue = '0, s_in_alpha = '0;
    logic        m_valid, m_ready = 1'b0;
    logic [7:0]  m_out_red, m_out_green, m_out_blue, m_out_alpha;
    logic        m_was_filtered, m_frame_end;

    convolution_3x3_rgb_filter u_dut (.*);

    always #6 aclk = ~aclk;

    // ---------------- filter predictor ----------------
    logic [62:0] cfg_kernel;
    logic [9:0]  cfg_div;
    logic [13:0] cfg_w, cfg_h;
    logic [1:0]  cfg_fmt;
    logic [31:0] line_mem [0:STORE_WORDS-1];
    int unsigned col_out, row_out, pend, rd_ptr;

    pix_in_t  tx_pending[$];
    pix_out_t px_expected[$];
    int       errors = 0;
    bit       calm = 1'b0;   // no idling on either side

    function automatic int unsigned eff_w();
        if (cfg_w == 0) return 1;
        if (cfg_w > LINE_MAX) return LINE_MAX;
        return cfg_w;
    endfunction

    function automatic int unsigned eff_h();
        if (cfg_h == 0) return 1;
        if (cfg_h > cvf_pkg::MAX_ROWS) return cvf_pkg::MAX_ROWS;
        return cfg_h;
    endfunction

    function automatic bit next_interior();
        int unsigned w, h;
        w = eff_w();
        h = eff_h();
        if (cfg_div == 0 || w < 3 || h < 3) return 1'b0;
        return row_out >= 1 && row_out + 2 <= h && col_out >= 1 && col_out + 2 <= w;
    endfunction

    function automatic logic [7:0] clamp_ch(input int sum);
        int q;
        q = sum / int'(cfg_div);
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic pix_out_t emit_pixel();
        pix_out_t    o;
        int unsigned w, h, idx;
        logic [31:0] px, nb;
        int          sr, sg, sb, wt;
        bit          gray;
        w = eff_w();
        h = eff_h();
        px = line_mem[rd_ptr];
        gray = (cfg_fmt == cvf_pkg::FMT_GRAY);
        o.filt = 1'b0;
        if (next_interior()) begin
            sr = 0; sg = 0; sb = 0;
            for (int k = 0; k < 9; k++) begin
                idx = (rd_ptr + STORE_WORDS - (w + 1) + (k / 3) * w + (k % 3)) % STORE_WORDS;
                nb = line_mem[idx];
                wt = int'($signed(cfg_kernel[7*k +: 7]));
                sr += wt * int'(nb[7:0]);
                sg += wt * int'(nb[15:8]);
                sb += wt * int'(nb[23:16]);
            end
            o.r = clamp_ch(sr);
            o.g = gray ? o.r : clamp_ch(sg);
            o.b = gray ? o.r : clamp_ch(sb);
            o.a = cvf_pkg::CH_MAX;
            o.filt = 1'b1;
        end else begin
            o.r = px[7:0];
            o.g = gray ? o.r : px[15:8];
            o.b = gray ? o.r : px[23:16];
            o.a = (cfg_fmt >= cvf_pkg::FMT_RGBA) ? px[31:24] : cvf_pkg::CH_MAX;
        end
        o.fend = (row_out + 1 >= h && col_out + 1 >= w);
        rd_ptr = (rd_ptr + 1) % STORE_WORDS;
        pend--;
        col_out++;
        if (col_out >= w) begin
            col_out = 0;
            row_out++;
            if (row_out >= h) row_out = 0;
        end
        return o;
    endfunction

    function automatic void predict_word(input pix_in_t it);
        if (it.op == cvf_pkg::OP_FLUSH) begin
            if (pend != 0 && !next_interior()) px_expected.push_back(emit_pixel());
        end else begin
            line_mem[(rd_ptr + pend) % STORE_WORDS] = {it.a, it.b, it.g, it.r};
            pend++;
            if (pend > eff_w() + 1) px_expected.push_back(emit_pixel());
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] v);
        case (idx)
            cvf_pkg::REG_KERNEL:  cfg_kernel = v[62:0];
            cvf_pkg::REG_DIVISOR: cfg_div = v[9:0];
            cvf_pkg::REG_WIDTH:   cfg_w = v[13:0];
            cvf_pkg::REG_HEIGHT:  cfg_h = v[13:0];
            cvf_pkg::REG_FORMAT:  cfg_fmt = v[1:0];
            default: ;
        endcase
        if (idx == cvf_pkg::REG_WIDTH || idx == cvf_pkg::REG_HEIGHT ||
            idx == cvf_pkg::REG_FORMAT) begin
            col_out = 0;
            row_out = 0;
            pend = 0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ---------------- driver ----------------
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_word('{s_operation, s_in_red, s_in_green, s_in_blue, s_in_alpha});
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (tx_pending.size() != 0) begin
                    pix_in_t it;
                    it = tx_pending.pop_front();
                    s_operation <= it.op;
                    s_in_red    <= it.r;
                    s_in_green  <= it.g;
                    s_in_blue   <= it.b;
                    s_in_alpha  <= it.a;
                    s_valid     <= 1'b1;
                    tx_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int rx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (px_expected.size() == 0) begin
                    $error("unexpected result word");
                    errors++;
                end else begin
                    pix_out_t e;
                    e = px_expected.pop_front();
                    if (m_out_red !== e.r) begin
                        $error("out_red exp %0d got %0d", e.r, m_out_red); errors++;
                    end
                    if (m_out_green !== e.g) begin
                        $error("out_green exp %0d got %0d", e.g, m_out_green); errors++;
                    end
                    if (m_out_blue !== e.b) begin
                        $error("out_blue exp %0d got %0d", e.b, m_out_blue); errors++;
                    end
                    if (m_out_alpha !== e.a) begin
                        $error("out_alpha exp %0d got %0d", e.a, m_out_alpha); errors++;
                    end
                    if (m_was_filtered !== e.filt) begin
                        $error("was_filtered exp %0d got %0d", e.filt, m_was_filtered);
                        errors++;
                    end
                    if (m_frame_end !== e.fend) begin
                        $error("frame_end exp %0d got %0d", e.fend, m_frame_end); errors++;
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_gap = pick_gap();
            end
        end
    end

    int unsigned cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** convolution_3x3_rgb_filter: FAILED **");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic wait_drained();
        do @(negedge aclk);
        while (tx_pending.size() != 0 || s_valid || px_expected.size() != 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        apply_reg(idx, v);
    endtask

    // drain, let the divider finish any word the last item started, then configure
    task automatic setup(input logic [62:0] k, input logic [9:0] d, input logic [13:0] w,
                         input logic [13:0] h, input logic [1:0] f);
        wait_drained();
        repeat (60) @(posedge aclk);
        reg_write(cvf_pkg::REG_KERNEL, {1'b0, k});
        reg_write(cvf_pkg::REG_DIVISOR, 64'(d));
        reg_write(cvf_pkg::REG_WIDTH, 64'(w));
        reg_write(cvf_pkg::REG_HEIGHT, 64'(h));
        reg_write(cvf_pkg::REG_FORMAT, 64'(f));
        @(negedge aclk);
    endtask

    function automatic logic [7:0] rnd_ch();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic void push_px(input logic [7:0] r, g, b, a);
        tx_pending.push_back('{cvf_pkg::OP_PIXEL, r, g, b, a});
    endfunction

    function automatic void push_flush(input int n);
        repeat (n)
            tx_pending.push_back('{cvf_pkg::OP_FLUSH, rnd_ch(), rnd_ch(), rnd_ch(), rnd_ch()});
    endfunction

    function automatic void push_rnd_px();
        push_px(rnd_ch(), rnd_ch(), rnd_ch(), rnd_ch());
    endfunction

    function automatic logic [62:0] rnd_kernel();
        logic [62:0] k;
        k = 63'({$urandom, $urandom});
        if ($urandom_range(3) == 0) begin
            // one kernel in four gets only small weights, from -3 to 3
            for (int i = 0; i < 9; i++) k[7*i +: 7] = 7'(int'($urandom_range(6)) - 3);
        end
        return k;
    endfunction

    int rnd_words = 0;
    int unsigned fw, fh, nframes, npx;

    initial begin
        for (int i = 0; i < STORE_WORDS; i++) line_mem[i] = '0;
        cfg_kernel = 63'd268435456;
        cfg_div = 10'd1;
        cfg_w = 14'd640;
        cfg_h = 14'd480;
        cfg_fmt = cvf_pkg::FMT_RGBA;
        col_out = 0; row_out = 0; pend = 0; rd_ptr = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: identity 3x3, extremes, flush of nothing and of border pixels
        @(negedge aclk);
        push_flush(1);
        setup(63'd268435456, 10'd1, 14'd3, 14'd3, cvf_pkg::FMT_RGBA);
        push_px(8'd0, 8'd0, 8'd0, 8'd0);
        push_px(8'd255, 8'd255, 8'd255, 8'd255);
        push_px(8'h55, 8'hAA, 8'h0F, 8'hF0);
        push_px(8'hAA, 8'h55, 8'hF0, 8'h0F);
        push_px(8'd255, 8'd0, 8'd255, 8'd0);
        push_px(8'd1, 8'd2, 8'd3, 8'd4);
        push_px(8'd128, 8'd127, 8'd64, 8'd200);
        push_px(8'd0, 8'd255, 8'd0, 8'd255);
        push_flush(1);
        push_px(8'd9, 8'd8, 8'd7, 8'd6);
        push_flush(6);
        // all weights at the negative and positive extremes
        setup({9{7'h40}}, 10'd1, 14'd3, 14'd3, cvf_pkg::FMT_RGB);
        repeat (9) push_rnd_px();
        push_flush(4);
        setup({9{7'h3F}}, 10'd1023, 14'd3, 14'd3, cvf_pkg::FMT_GRAY);
        repeat (9) push_rnd_px();
        push_flush(4);
        // thinnest and widest frames, all border
        setup(rnd_kernel(), 10'd1, 14'd1, 14'd1, cvf_pkg::FMT_RGBA);
        repeat (4) push_rnd_px();
        push_flush(2);
        setup(rnd_kernel(), 10'd5, 14'd2, 14'd7, cvf_pkg::FMT_RGB);
        repeat (14) push_rnd_px();
        push_flush(3);
        calm = 1'b1;
        setup(rnd_kernel(), 10'd3, 14'd9000, 14'd1, cvf_pkg::FMT_RGBA);
        repeat (40) push_rnd_px();
        push_flush(40);
        wait_drained();
        calm = 1'b0;
        // tallest frame: a few rows, then drop the rest by reconfiguring
        setup(rnd_kernel(), 10'd2, 14'd3, 14'd8192, cvf_pkg::FMT_RGB);
        repeat (24) push_rnd_px();
        push_flush(3);

        // random phases
        while (rnd_words < 560) begin
            fw = ($urandom_range(7) == 0) ? $urandom_range(2, 1) : $urandom_range(10, 3);
            fh = ($urandom_range(7) == 0) ? $urandom_range(2, 1) : $urandom_range(5, 3);
            setup(rnd_kernel(),
                  ($urandom_range(3) == 0) ? 10'($urandom_range(1023, 1))
                                           : 10'($urandom_range(16, 1)),
                  14'(fw), 14'(fh), 2'($urandom_range(2)));
            calm = ($urandom_range(4) == 0);
            nframes = $urandom_range(3, 1);
            npx = fw * fh * nframes;
            if ($urandom_range(5) == 0) npx = $urandom_range(npx);   // cut-off frame
            for (int i = 0; i < npx; i++) begin
                if ($urandom_range(19) == 0) push_flush(1);
                push_rnd_px();
                if (i == npx / 2 && $urandom_range(3) == 0) wait_drained();
            end
            push_flush(fw + 1 + $urandom_range(2));
            rnd_words += npx;
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("** convolution_3x3_rgb_filter: PASSED **");
        end else begin
            $display("** convolution_3x3_rgb_filter: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
src/cvf_pkg.sv
src/cvf_ram.sv
src/cvf_ctrl.sv
src/cvf_dp.sv
src/convolution_3x3_rgb_filter.sv
dv/testbench.sv
